### rtl/lct_pkg.sv
// Shared types and constants for the max line tree block.
// No dependencies; every other file refers to this package by scoped names.
package lct_pkg;

    localparam int XBITS  = 10;
    localparam int NODES  = 1 << (XBITS + 1);
    localparam int AW     = XBITS + 1;   // node address width
    localparam int IW     = XBITS + 2;   // node index width, top bit flags overflow
    localparam int XW     = 24;
    localparam int PW     = XW + 1;      // evaluation point width
    localparam int MW     = 32;
    localparam int BW     = 48;
    localparam int LW     = MW + PW + 1; // line value width
    localparam int VW     = 61;
    localparam int CIW    = 2;           // config index width

    localparam logic [CIW-1:0] REG_X_LOW  = 2'd0;
    localparam logic [CIW-1:0] REG_X_HIGH = 2'd1;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic signed [VW-1:0] NEG_VALUE = {1'b1, {(VW-1){1'b0}}};

    typedef struct packed {
        logic                 req_type;
        logic signed [MW-1:0] slope;
        logic signed [BW-1:0] intercept;
        logic signed [XW-1:0] x;
    } req_t;

    typedef struct packed {
        logic signed [VW-1:0] value;
        logic                 out_of_range;
    } result_t;

    typedef struct packed {
        logic load;
        logic clr_start;
        logic clr_step;
        logic eval;
        logic step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic skip;
        logic done;
    } status_t;

    // Value of a line at a point.
    function automatic logic signed [LW-1:0] line_at(
        input logic signed [MW-1:0] m,
        input logic signed [BW-1:0] b,
        input logic signed [PW-1:0] px
    );
        logic signed [LW-1:0] p;
        p = LW'(m) * LW'(px);
        return p + LW'(b);
    endfunction

endpackage

### rtl/lct_ctrl.sv
// Sequencer for the max line tree: clearing pass, per-level read/eval/decide.
// Depends on lct_pkg for command and status types.
module lct_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             cfg_hit,
    input  lct_pkg::status_t status,
    output lct_pkg::cmd_t    cmd,
    output logic             idle
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD,
        ST_EVAL,
        ST_DECIDE
    } state_t;

    state_t state_reg, state_next;

    // Decode commands and next state
    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                    state_next = ST_IDLE;
            end
            ST_RD:
            begin
                if (status.skip)
                begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.step = 1'b1;
                if (status.done)
                begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_RD;
            end
            default:
                state_next = ST_IDLE;
        endcase
        // restart the clearing pass on any range write
        if (cfg_hit)
        begin
            cmd = '0;
            cmd.clr_start = 1'b1;
            state_next = ST_CLEAR;
        end
    end

    assign idle = (state_reg == ST_IDLE);

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/lct_dpath.sv
// Datapath of the max line tree: range registers, node memories, line evaluation.
// Depends on lct_pkg for types, widths and the line evaluation function.
module lct_dpath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lct_pkg::cmd_t             cmd,
    input  lct_pkg::req_t             req,
    input  logic                      cfg_we,
    input  logic [lct_pkg::CIW-1:0]   cfg_index,
    input  logic [lct_pkg::XW-1:0]    cfg_data,
    output lct_pkg::status_t          status,
    output logic                      result_valid,
    output lct_pkg::result_t          result
);

    localparam int XB = lct_pkg::XBITS;

    logic signed [lct_pkg::XW-1:0] x_low_reg, x_high_reg;

    // node memories
    logic [lct_pkg::MW+lct_pkg::BW-1:0] line_mem [lct_pkg::NODES];
    logic                               valid_mem [lct_pkg::NODES];
    logic [lct_pkg::MW+lct_pkg::BW-1:0] line_rd_reg;
    logic                               valid_rd_reg;

    // walk state
    logic [lct_pkg::IW-1:0]        idx_reg;
    logic [XB-1:0]                 a_reg, e_reg, qoff_reg;
    logic                          qry_reg, skip_reg;
    logic signed [lct_pkg::MW-1:0] m_reg;
    logic signed [lct_pkg::BW-1:0] b_reg;
    logic signed [lct_pkg::XW-1:0] x_reg;
    logic signed [lct_pkg::VW-1:0] best_reg;
    logic [lct_pkg::AW-1:0]        cnt_reg;

    logic signed [lct_pkg::LW-1:0] sl_reg, sr_reg, sm_reg, nl_reg, nr_reg, nm_reg;

    // Range check of the incoming request
    logic signed [lct_pkg::PW-1:0] span_w, off_w;
    logic                          rev_w, oor_w;
    logic [XB-1:0]                 span_c;
    always_comb
    begin
        span_w = lct_pkg::PW'(x_high_reg) - lct_pkg::PW'(x_low_reg);
        off_w  = lct_pkg::PW'(req.x) - lct_pkg::PW'(x_low_reg);
        rev_w  = span_w < 0;
        if (span_w > $signed(lct_pkg::PW'({XB{1'b1}})))
            span_c = {XB{1'b1}};
        else
            span_c = span_w[XB-1:0];
        oor_w = rev_w || (off_w < 0) || (off_w > $signed(lct_pkg::PW'(span_c)));
    end

    // Split the stored line and work out the midpoint
    logic signed [lct_pkg::MW-1:0] sm_w;
    logic signed [lct_pkg::BW-1:0] sb_w;
    logic [XB:0]                   sum_w;
    logic [XB-1:0]                 mo_w;
    logic signed [lct_pkg::PW-1:0] pl_w, pr_w, pm_w;
    assign sm_w  = line_rd_reg[lct_pkg::MW+lct_pkg::BW-1:lct_pkg::BW];
    assign sb_w  = line_rd_reg[lct_pkg::BW-1:0];
    assign sum_w = {1'b0, a_reg} + {1'b0, e_reg};
    assign mo_w  = sum_w[XB:1];
    assign pl_w  = qry_reg ? lct_pkg::PW'(x_reg)
                           : lct_pkg::PW'(x_low_reg) + lct_pkg::PW'({1'b0, a_reg});
    assign pr_w  = lct_pkg::PW'(x_low_reg) + lct_pkg::PW'({1'b0, e_reg});
    assign pm_w  = lct_pkg::PW'(x_low_reg) + lct_pkg::PW'({1'b0, mo_w});

    // Decide the step at the current node
    logic                          swap_w, keep_w, right_w, done_w;
    logic signed [lct_pkg::LW-1:0] lr_w, hr_w, lmv_w, hmv_w;
    logic signed [lct_pkg::MW-1:0] lo_m, hi_m, wr_m, carry_m;
    logic signed [lct_pkg::BW-1:0] lo_b, hi_b, wr_b, carry_b;
    logic signed [lct_pkg::VW-1:0] best_w, sl_ext;
    logic [lct_pkg::IW-1:0]        idx_nx;
    always_comb
    begin
        // stored line at or above the new one at the left end: new line is the lower
        swap_w = sl_reg >= nl_reg;
        lo_m = swap_w ? m_reg : sm_w;
        lo_b = swap_w ? b_reg : sb_w;
        hi_m = swap_w ? sm_w : m_reg;
        hi_b = swap_w ? sb_w : b_reg;
        lr_w  = swap_w ? nr_reg : sr_reg;
        hr_w  = swap_w ? sr_reg : nr_reg;
        lmv_w = swap_w ? nm_reg : sm_reg;
        hmv_w = swap_w ? sm_reg : nm_reg;
        keep_w = lr_w <= hr_w;
        if (qry_reg)
            right_w = qoff_reg > mo_w;
        else
            right_w = lmv_w < hmv_w;
        if (!valid_rd_reg)
        begin
            wr_m = m_reg;
            wr_b = b_reg;
        end
        else if (keep_w || right_w)
        begin
            wr_m = hi_m;
            wr_b = hi_b;
        end
        else
        begin
            wr_m = lo_m;
            wr_b = lo_b;
        end
        carry_m = right_w ? lo_m : hi_m;
        carry_b = right_w ? lo_b : hi_b;
        idx_nx = {idx_reg[lct_pkg::IW-2:0], right_w};
        sl_ext = lct_pkg::VW'(sl_reg);
        best_w = (valid_rd_reg && (sl_ext > best_reg)) ? sl_ext : best_reg;
        done_w = !valid_rd_reg || idx_nx[lct_pkg::IW-1] || (!qry_reg && keep_w);
    end

    assign status.clr_last = &cnt_reg;
    assign status.skip     = skip_reg;
    assign status.done     = done_w;

    // Range registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg  <= '0;
            x_high_reg <= lct_pkg::XW'(1023);
        end
        else if (cfg_we)
        begin
            if (cfg_index == lct_pkg::REG_X_LOW)
                x_low_reg <= cfg_data;
            else if (cfg_index == lct_pkg::REG_X_HIGH)
                x_high_reg <= cfg_data;
        end
    end

    // Clear counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.clr_start)
            cnt_reg <= '0;
        else if (cmd.clr_step)
            cnt_reg <= cnt_reg + 1'b1;
    end

    // Node memories: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            valid_mem[cnt_reg] <= 1'b0;
        else if (cmd.step && !qry_reg)
            valid_mem[idx_reg[lct_pkg::AW-1:0]] <= 1'b1;
        if (cmd.step && !qry_reg)
            line_mem[idx_reg[lct_pkg::AW-1:0]] <= {wr_m, wr_b};
        valid_rd_reg <= valid_mem[idx_reg[lct_pkg::AW-1:0]];
        line_rd_reg  <= line_mem[idx_reg[lct_pkg::AW-1:0]];
    end

    // Walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            qry_reg  <= req.req_type == lct_pkg::REQ_QUERY;
            skip_reg <= (req.req_type == lct_pkg::REQ_QUERY) ? oor_w : rev_w;
            m_reg    <= req.slope;
            b_reg    <= req.intercept;
            x_reg    <= req.x;
            qoff_reg <= off_w[XB-1:0];
            a_reg    <= '0;
            e_reg    <= span_c;
            idx_reg  <= lct_pkg::IW'(1);
            best_reg <= lct_pkg::NEG_VALUE;
        end
        else if (cmd.eval)
        begin
            sl_reg <= lct_pkg::line_at(sm_w, sb_w, pl_w);
            sr_reg <= lct_pkg::line_at(sm_w, sb_w, pr_w);
            sm_reg <= lct_pkg::line_at(sm_w, sb_w, pm_w);
            nl_reg <= lct_pkg::line_at(m_reg, b_reg, pl_w);
            nr_reg <= lct_pkg::line_at(m_reg, b_reg, pr_w);
            nm_reg <= lct_pkg::line_at(m_reg, b_reg, pm_w);
        end
        else if (cmd.step)
        begin
            best_reg <= best_w;
            idx_reg  <= idx_nx;
            if (!qry_reg)
            begin
                m_reg <= carry_m;
                b_reg <= carry_b;
            end
            if (right_w)
                a_reg <= mo_w + 1'b1;
            else
                e_reg <= mo_w;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else
            result_valid <= cmd.emit && qry_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result.value        <= skip_reg ? lct_pkg::NEG_VALUE : best_w;
            result.out_of_range <= skip_reg;
        end
    end

endmodule

### rtl/li_chao_max_line_tree.sv
// Max line tree: an add or query walks up to XBITS+1 levels; each level runs a
// memory read, six parallel line evaluations and a decide, in that order.
// One request at a time; busy stays high for the whole walk, so a new request is
// taken only once the last one is through. Results are one-cycle strobes.
// After reset, and after each write of x_low or x_high, a clearing pass
// sweeps all 2^(XBITS+1) entries of the node valid store while busy is high.
module li_chao_max_line_tree (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  lct_pkg::req_t           req,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [lct_pkg::CIW-1:0] cfg_index,
    input  logic [lct_pkg::XW-1:0]  cfg_data,
    output logic                    result_valid,
    output lct_pkg::result_t        result
);

    lct_pkg::cmd_t    cmd;
    lct_pkg::status_t status;
    logic             idle, cfg_hit;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && ((cfg_index == lct_pkg::REG_X_LOW) ||
                                     (cfg_index == lct_pkg::REG_X_HIGH));
    assign busy      = !idle || cfg_valid;

    lct_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start && !busy),
        .cfg_hit(cfg_hit),
        .status (status),
        .cmd    (cmd),
        .idle   (idle)
    );

    lct_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req         (req),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .status      (status),
        .result_valid(result_valid),
        .result      (result)
    );

endmodule

### rtl/lct_checker.sv
// Port-level checks for the max line tree, bound to the top level.
// Depends on lct_pkg for the config register codes.
module lct_port_props (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    cfg_valid,
    input logic                    cfg_ready,
    input logic [lct_pkg::CIW-1:0] cfg_index,
    input logic                    result_valid
);

    // accepted request keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy low right after an accepted request");

    // range write starts the clearing pass
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready &&
        ((cfg_index == lct_pkg::REG_X_LOW) || (cfg_index == lct_pkg::REG_X_HIGH))
        |=> busy)
        else $error("range write did not start clearing");

    // results only come out of work in progress
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a request in flight");

    // one strobe per query
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

endmodule

bind li_chao_max_line_tree lct_port_props u_lct_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .result_valid(result_valid)
);
